/* rtl/uvst_pkg.sv */
// Package of shared constants and types for the unique value set table.
package uvst_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountW      = 5;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic                     cmp_en;
    logic                     add_en;
    logic                     rm_en;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

/* rtl/uvst_if.sv */
// Request and response channel interfaces of the unique value set table.
interface uvst_req_if
  import uvst_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface uvst_rsp_if
  import uvst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic              full_reject;
  logic [CountW-1:0] count;
  logic              empty_res;

  modport source (output valid, output hit, output full_reject, output count,
                  output empty_res, input ready);
  modport sink (input valid, input hit, input full_reject, input count,
                input empty_res, output ready);
endinterface

/* rtl/uvst_cell.sv */
// One storage cell of the table: entry, compare and shift towards its neighbour.
module uvst_cell
  import uvst_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic                     valid_i,
  input  logic                     tail_i,
  input  logic                     found_i,
  input  logic signed [ValueW-1:0] next_entry_i,
  output logic                     found_o,
  output logic signed [ValueW-1:0] entry_o
);

  logic                     match_q, match_d;
  logic signed [ValueW-1:0] entry_q, entry_d;

  assign found_o = found_i | match_q;
  assign entry_o = entry_q;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_i && (entry_q == ctrl_i.value);
    end
    entry_d = entry_q;
    if (ctrl_i.add_en && tail_i) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.rm_en && found_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* rtl/unique_value_set_table.sv */
// Top level of the unique value set table: request control and the row of cells.
//
// A request beat on req_i carries an operation (add, remove, search) and a
// signed 32-bit value; every request gives exactly one response beat on rsp_o
// with the hit flag, the full-table reject flag, the count afterwards and an
// empty flag. Values are kept distinct and in insertion order; a removal
// closes the gap by moving every later entry one cell towards the head.
// A request runs through three steps: in ST_IDLE the beat is taken, in ST_CMP
// every cell compares its entry with the value, and in ST_UPD the found flag
// ripples along the row of cells, the entries and the count are updated and
// the response register is loaded. The next request is taken in the cycle
// after the update, so a new request waits until the previous one is through.
// At reset the table is empty and no response is pending.
// When the receiver stalls, the finished response waits in its register and
// a following request holds in its update step until that beat is taken.
module unique_value_set_table
  import uvst_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uvst_req_if.sink   req_i,
  uvst_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e                   state_q, state_d;
  logic [1:0]               op_q;
  logic signed [ValueW-1:0] value_q;
  logic [CntW-1:0]          count_q, count_d;
  logic                     rsp_valid_q, rsp_valid_d;
  logic                     hit_q, hit_d;
  logic                     reject_q, reject_d;
  logic                     upd_fire;
  logic                     present;
  logic                     full;
  cell_ctrl_t               ctrl;
  logic [CAPACITY:0]        found_w;
  logic signed [ValueW-1:0] entry_w [CAPACITY];
  logic [CntW+CountW-1:0]   count_ext;

  assign full     = (count_q == CntW'(CAPACITY));
  assign present  = found_w[CAPACITY];
  assign upd_fire = (state_q == ST_UPD) && (!rsp_valid_q || rsp_o.ready);
  assign found_w[0] = 1'b0;

  assign ctrl.cmp_en = (state_q == ST_CMP);
  assign ctrl.add_en = upd_fire && (op_q == OP_ADD) && !present && !full;
  assign ctrl.rm_en  = upd_fire && (op_q == OP_REMOVE) && present;
  assign ctrl.value  = value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] next_entry;
    if (i + 1 < CAPACITY) begin : g_mid
      assign next_entry = entry_w[i+1];
    end else begin : g_last
      assign next_entry = entry_w[i];
    end
    uvst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .valid_i     (CntW'(i) < count_q),
      .tail_i      (CntW'(i) == count_q),
      .found_i     (found_w[i]),
      .next_entry_i(next_entry),
      .found_o     (found_w[i+1]),
      .entry_o     (entry_w[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rsp_valid_d = rsp_valid_q;
    hit_d       = hit_q;
    reject_d    = reject_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
          hit_d       = ctrl.add_en || ctrl.rm_en || ((op_q == OP_SEARCH) && present);
          reject_d    = (op_q == OP_ADD) && !present && full;
          if (ctrl.add_en) begin
            count_d = count_q + CntW'(1);
          end else if (ctrl.rm_en) begin
            count_d = count_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q    <= hit_d;
    reject_q <= reject_d;
    if (req_i.valid && req_i.ready) begin
      op_q    <= req_i.op;
      value_q <= req_i.value;
    end
  end

  assign count_ext = {{CountW{1'b0}}, count_q};

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = hit_q;
  assign rsp_o.full_reject = reject_q;
  assign rsp_o.count       = count_ext[CountW-1:0];
  assign rsp_o.empty_res   = (count_q == '0);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("Entry count exceeds the capacity.");

  a_reject_no_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && reject_q |-> !hit_q)
    else $error("A refused add also reports a hit.");

  a_upd_gives_rsp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> rsp_valid_q && (state_q == ST_IDLE))
    else $error("An update step did not load a response.");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_fire |=> $stable(count_q))
    else $error("Entry count changed outside an update step.");

endmodule
